// ===== rtl/ppac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppac_pkg: shared types and constants for the palette pixel compositor
// Holds the source format codes, the configuration register indexes, the
// shadow blend table and the record that leaves the source decode stage.
// ----------------------------------------------------------------------------
package ppac_pkg;

  // Source pixel formats; the codes not listed pass the destination through.
  localparam logic [2:0] FMT_MONO1 = 3'd0;
  localparam logic [2:0] FMT_ARGB8 = 3'd1;
  localparam logic [2:0] FMT_PAL1  = 3'd2;
  localparam logic [2:0] FMT_PAL2  = 3'd3;
  localparam logic [2:0] FMT_PAL4  = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_HIGH = 2'd2;

  localparam int unsigned CFG_DATA_W = 64;

  // Fixed colors written by the mono format.
  localparam logic [7:0] MONO_WHITE = 8'hFF;
  localparam logic [7:0] MONO_BLACK = 8'hC0;

  // Decoded request leaving the first stage.
  typedef struct packed {
    logic       direct;  // result is pix itself, no blending
    logic [7:0] pix;     // foreground color or the final result
    logic [7:0] bg;      // destination pixel
  } ppac_dec_t;

  // Shadow table used by the blend.
  localparam logic [7:0] SHADE_TAB [0:255] = '{
    8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,
    8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,
    8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,
    8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,
    8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,
    8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,
    8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,
    8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,8'd192,
    8'd192,8'd192,8'd192,8'd193,8'd192,8'd192,8'd192,8'd193,
    8'd192,8'd192,8'd192,8'd193,8'd196,8'd196,8'd196,8'd197,
    8'd192,8'd192,8'd192,8'd193,8'd192,8'd192,8'd192,8'd193,
    8'd192,8'd192,8'd192,8'd193,8'd196,8'd196,8'd196,8'd197,
    8'd192,8'd192,8'd192,8'd193,8'd192,8'd192,8'd192,8'd193,
    8'd192,8'd192,8'd192,8'd193,8'd196,8'd196,8'd196,8'd197,
    8'd208,8'd208,8'd208,8'd209,8'd208,8'd208,8'd208,8'd209,
    8'd208,8'd208,8'd208,8'd209,8'd212,8'd212,8'd212,8'd213,
    8'd192,8'd192,8'd193,8'd194,8'd192,8'd192,8'd193,8'd194,
    8'd196,8'd196,8'd197,8'd198,8'd200,8'd200,8'd201,8'd202,
    8'd192,8'd192,8'd193,8'd194,8'd192,8'd192,8'd193,8'd194,
    8'd196,8'd196,8'd197,8'd198,8'd200,8'd200,8'd201,8'd202,
    8'd208,8'd208,8'd209,8'd210,8'd208,8'd208,8'd209,8'd210,
    8'd212,8'd212,8'd213,8'd214,8'd216,8'd216,8'd217,8'd218,
    8'd224,8'd224,8'd225,8'd226,8'd224,8'd224,8'd225,8'd226,
    8'd228,8'd228,8'd229,8'd230,8'd232,8'd232,8'd233,8'd234,
    8'd192,8'd193,8'd194,8'd195,8'd196,8'd197,8'd198,8'd199,
    8'd200,8'd201,8'd202,8'd203,8'd204,8'd205,8'd206,8'd207,
    8'd208,8'd209,8'd210,8'd211,8'd212,8'd213,8'd214,8'd215,
    8'd216,8'd217,8'd218,8'd219,8'd220,8'd221,8'd222,8'd223,
    8'd224,8'd225,8'd226,8'd227,8'd228,8'd229,8'd230,8'd231,
    8'd232,8'd233,8'd234,8'd235,8'd236,8'd237,8'd238,8'd239,
    8'd240,8'd241,8'd242,8'd243,8'd244,8'd245,8'd246,8'd247,
    8'd248,8'd249,8'd250,8'd251,8'd252,8'd253,8'd254,8'd255
  };

endpackage : ppac_pkg
`default_nettype wire

// ===== rtl/ppac_src_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppac_src_decode: source pixel unpack and palette lookup
// Picks the pixel out of the packed source byte for the active format, maps
// palette indexes through the 16-entry palette and flags the results that
// bypass the blend (mono and pass-through).
// ----------------------------------------------------------------------------
module ppac_src_decode (
  input  wire logic [2:0]       pixel_format,
  input  wire logic [63:0]      palette_low,
  input  wire logic [63:0]      palette_high,
  input  wire logic [7:0]       dest_pixel,
  input  wire logic [7:0]       source_byte,
  input  wire logic [2:0]       pixel_slot,
  output      ppac_pkg::ppac_dec_t dec
);
  import ppac_pkg::*;

  logic [127:0] pal_flat;
  logic [2:0]   bit_pos;
  logic [1:0]   pair_pos;
  logic         nib_pos;
  logic         bit1;
  logic [3:0]   pal_idx;

  // Slot 0 is the most significant pixel, so positions count from the top.
  assign pal_flat = {palette_high, palette_low};
  assign bit_pos  = ~pixel_slot;
  assign pair_pos = ~pixel_slot[1:0];
  assign nib_pos  = ~pixel_slot[0];
  assign bit1     = source_byte[bit_pos];

  // Palette index for the three palette formats.
  always_comb begin
    case (pixel_format)
      FMT_PAL2: pal_idx = {2'b00, source_byte[{pair_pos, 1'b0} +: 2]};
      FMT_PAL4: pal_idx = source_byte[{nib_pos, 2'b00} +: 4];
      default:  pal_idx = {3'b000, bit1};
    endcase
  end

  // Foreground selection per format.
  always_comb begin
    dec.bg = dest_pixel;
    case (pixel_format)
      FMT_MONO1: begin
        dec.direct = 1'b1;
        dec.pix    = bit1 ? MONO_WHITE : MONO_BLACK;
      end
      FMT_ARGB8: begin
        dec.direct = 1'b0;
        dec.pix    = source_byte;
      end
      FMT_PAL1, FMT_PAL2, FMT_PAL4: begin
        dec.direct = 1'b0;
        dec.pix    = pal_flat[{pal_idx, 3'b000} +: 8];
      end
      default: begin
        dec.direct = 1'b1;
        dec.pix    = dest_pixel;
      end
    endcase
  end

endmodule : ppac_src_decode
`default_nettype wire

// ===== rtl/palette_pixel_alpha_compositor_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palette_pixel_alpha_compositor_top: ARGB2222 palette pixel compositor
// Composites one source pixel (mono, ARGB8 or 1/2/4-bit palette) onto one
// framebuffer pixel through the shadow table blend.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   in      | in_valid, in_stall, in_dest_pixel,     | request in
//           | in_source_byte, in_pixel_slot          |
//   out     | out_valid, out_stall, out_pixel_out    | request out
//   cfg     | cfg_we, cfg_index, cfg_data            | write only
//
// Three register stages: decode/palette, table lookup, add. One request per
// clock unless out_stall holds a full pipe; a request passes stage 1, stage 2
// and the output register before out_valid rises for it.
// Each stage holds its request while the next one is full and stalled, so an
// empty stage still takes new work; in_stall rises only with all stages full.
// Synchronous active-low reset empties the pipe and sets format to ARGB8 and
// the palette to zero.
// ----------------------------------------------------------------------------
module palette_pixel_alpha_compositor_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [7:0]                     in_dest_pixel,
  input  wire logic [7:0]                     in_source_byte,
  input  wire logic [2:0]                     in_pixel_slot,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic [7:0]                     out_pixel_out,
  input  wire logic                           cfg_we,
  input  wire logic [ppac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ppac_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ppac_pkg::*;

  // Configuration registers.
  logic [2:0]  fmt_r;
  logic [63:0] pal_low_r;
  logic [63:0] pal_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r      <= FMT_ARGB8;
      pal_low_r  <= '0;
      pal_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_FORMAT: fmt_r      <= cfg_data[2:0];
        CFG_PALETTE_LOW:  pal_low_r  <= cfg_data;
        CFG_PALETTE_HIGH: pal_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage flow control.
  logic s1_v_r, s2_v_r, out_v_r;
  logic adv1, adv2, adv3;

  assign adv3     = !out_v_r || !out_stall;
  assign adv2     = !s2_v_r || adv3;
  assign adv1     = !s1_v_r || adv2;
  assign in_stall = !adv1;

  // Stage 1: source unpack and palette lookup.
  ppac_dec_t dec;
  ppac_dec_t s1_r;

  ppac_src_decode u_decode (
    .pixel_format (fmt_r),
    .palette_low  (pal_low_r),
    .palette_high (pal_high_r),
    .dest_pixel   (in_dest_pixel),
    .source_byte  (in_source_byte),
    .pixel_slot   (in_pixel_slot),
    .dec          (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_r <= dec;
    end
  end

  // Stage 2: both shadow table lookups.
  logic       s2_direct_r;
  logic [7:0] s2_pix_r;
  logic [5:0] s2_ta_r;
  logic [7:0] s2_tb_r;
  logic [7:0] ta_idx;
  logic [7:0] ta_val;

  // (~fg & 0xC0) + (bg & 63) never carries, so it is a concatenation.
  assign ta_idx = {~s1_r.pix[7:6], s1_r.bg[5:0]};
  assign ta_val = SHADE_TAB[ta_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_v_r) begin
      s2_direct_r <= s1_r.direct;
      s2_pix_r    <= s1_r.pix;
      s2_ta_r     <= ta_val[5:0];
      s2_tb_r     <= SHADE_TAB[s1_r.pix];
    end
  end

  // Stage 3: blend sum into the output register.
  logic [7:0] blend_sum;
  logic [7:0] out_pix_r;

  assign blend_sum = {2'b00, s2_ta_r} + s2_tb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv3) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_v_r) begin
      out_pix_r <= s2_direct_r ? s2_pix_r : blend_sum;
    end
  end

  assign out_valid     = out_v_r;
  assign out_pixel_out = out_pix_r;

  // The input only backs up when every stage holds a request.
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && out_v_r))
    else $error("input stalled while a stage is empty");

  // The blend sum never wraps with this table.
  a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s2_direct_r) |-> (({3'b000, s2_ta_r} + {1'b0, s2_tb_r}) <= 9'd255))
    else $error("blend sum overflowed");

  // A request in stage 2 with an empty output register moves on next cycle.
  a_s2_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !out_v_r) |=> out_v_r)
    else $error("stage 2 request did not reach the output register");

  // A request waiting in stage 1 behind a stalled full pipe stays put.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv2) |=> (s1_v_r && $stable(s1_r)))
    else $error("stage 1 request lost during stall");

endmodule : palette_pixel_alpha_compositor_top
`default_nettype wire
